// File: rtl/lis_pkg.sv
// lis_pkg: shared types and constants for the longest increasing subsequence unit.
// Used by lis_cell and longest_increasing_subsequence_length_unit; no dependencies.

package lis_pkg;

   // Field widths fixed by the external interface
   localparam int unsigned IN_VALUE_W = 32;
   localparam int unsigned LEN_W      = 9;
   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   // Input word: one element of the sequence
   typedef struct packed {
      logic signed [IN_VALUE_W-1:0] value;
      logic                         last;
   } lis_req_type;

   // Result word: emitted once per sequence
   typedef struct packed {
      logic [LEN_W-1:0] length;
      logic             overflow;
   } lis_rsp_type;

   // Probe control travelling down the cell chain alongside key and index
   typedef struct packed {
      logic             valid;
      logic             last;
      logic             overflow;
      logic [LEN_W-1:0] cmp_len;   // greatest length among smaller earlier elements
      logic [LEN_W-1:0] best_len;  // running maximum length of the sequence
   } lis_ctl_type;

endpackage

// File: rtl/lis_cell.sv
// lis_cell: one cell of the chain; stores one element and its subsequence length,
// and updates the probe passing through it. Depends on lis_pkg.

module lis_cell #(
   parameter int unsigned POSITION    = 0,
   parameter int unsigned VALUE_WIDTH = 32,
   parameter int unsigned IDX_W       = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  lis_pkg::lis_ctl_type          in_ctl,
   input  logic signed [VALUE_WIDTH-1:0] in_key,
   input  logic [IDX_W-1:0]              in_idx,
   output lis_pkg::lis_ctl_type          out_ctl,
   output logic signed [VALUE_WIDTH-1:0] out_key,
   output logic [IDX_W-1:0]              out_idx
);

   localparam logic [IDX_W-1:0] POS = IDX_W'(POSITION);

   // probe pipeline register
   lis_pkg::lis_ctl_type          ctl_ff, ctl_in;
   logic signed [VALUE_WIDTH-1:0] key_ff;
   logic [IDX_W-1:0]              idx_ff;

   // stored element
   logic signed [VALUE_WIDTH-1:0]  stored_key_ff;
   logic [lis_pkg::LEN_W-1:0]      stored_len_ff, stored_len_in;
   logic                           store_en;
   logic [lis_pkg::LEN_W-1:0]      new_len;

   // length ending at this element, saturating
   assign new_len = (in_ctl.cmp_len == lis_pkg::LEN_MAX) ? lis_pkg::LEN_MAX
                                                         : in_ctl.cmp_len + 1'b1;
   assign store_en      = advance && in_ctl.valid && (in_idx == POS);
   assign stored_len_in = new_len;

   // probe update: compare against held element of this sequence; own slot folds in new_len
   always_comb begin
      ctl_in = in_ctl;
      if (in_idx > POS) begin
         if ((stored_key_ff < in_key) && (stored_len_ff > in_ctl.cmp_len)) begin
            ctl_in.cmp_len = stored_len_ff;
         end
         if (stored_len_ff > in_ctl.best_len) begin
            ctl_in.best_len = stored_len_ff;
         end
      end else if (in_idx == POS) begin
         if (new_len > in_ctl.best_len) begin
            ctl_in.best_len = new_len;
         end
      end
   end

   // probe register (only the valid flag is reset) and stored element
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (advance) begin
         ctl_ff.last     <= ctl_in.last;
         ctl_ff.overflow <= ctl_in.overflow;
         ctl_ff.cmp_len  <= ctl_in.cmp_len;
         ctl_ff.best_len <= ctl_in.best_len;
         key_ff          <= in_key;
         idx_ff          <= in_idx;
      end
      if (store_en) begin
         stored_key_ff <= in_key;
         stored_len_ff <= stored_len_in;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_key = key_ff;
   assign out_idx = idx_ff;

endmodule

// File: rtl/longest_increasing_subsequence_length_unit.sv
// longest_increasing_subsequence_length_unit: top level; head counter, chain of
// lis_cell instances and result register. Depends on lis_pkg and lis_cell.
//
// Usage: elements of a sequence arrive on the req_ channel (req_valid, req_stall,
// req_data), one word per element, with last set on the final element. For every
// word with last set one result word leaves on the rsp_ channel (rsp_valid,
// rsp_stall, rsp_data) carrying the strictly increasing subsequence length and
// an overflow flag set when the sequence held more than MAX_N elements (extra
// elements are dropped).
// Throughput: one word per cycle while not stalled. Each word walks a chain of MAX_N
// cells, one cell per cycle while not stalled, through each cell's register and then
// the result register, so the chain length sets the latency of the result.
// Reset: synchronous; clears the element counter, the overflow flag and all
// valid flags. Cell contents need no clearing: a cell is consulted only by
// later elements of the sequence that wrote it.
// Stall: while a result waits with rsp_stall high the whole chain freezes and
// req_stall is raised; it resumes once the result is taken.

module longest_increasing_subsequence_length_unit #(
   parameter int unsigned MAX_N       = 256,
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lis_pkg::lis_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lis_pkg::lis_rsp_type rsp_data
);

   localparam int unsigned IDX_W = $clog2(MAX_N + 1);
   localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(MAX_N);

   logic                           advance;
   logic                           accept;
   logic signed [VALUE_WIDTH-1:0]  key_in;
   logic [IDX_W-1:0]               count_ff, count_in;
   logic                           ovf_ff, ovf_in;
   logic                           full;
   lis_pkg::lis_ctl_type           head_ctl;

   lis_pkg::lis_ctl_type           chain_ctl [MAX_N+1];
   logic signed [VALUE_WIDTH-1:0]  chain_key [MAX_N+1];
   logic [IDX_W-1:0]               chain_idx [MAX_N+1];

   logic                           rsp_valid_ff, rsp_valid_in;
   lis_pkg::lis_rsp_type           rsp_data_ff, rsp_data_in;
   logic                           rsp_load;

   // chain moves unless a result is held and stalled
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   // element key from the low VALUE_WIDTH bits, sign extended if wider
   generate
      if (VALUE_WIDTH <= lis_pkg::IN_VALUE_W) begin : g_key_narrow
         assign key_in = req_data.value[VALUE_WIDTH-1:0];
      end else begin : g_key_wide
         assign key_in = {{(VALUE_WIDTH-lis_pkg::IN_VALUE_W){req_data.value[
                            lis_pkg::IN_VALUE_W-1]}}, req_data.value};
      end
   endgenerate

   // head: element counter and overflow tracking
   assign full = (count_ff == IDX_FULL);

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (req_data.last) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end else if (full) begin
            ovf_in   = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_comb begin
      head_ctl.valid    = accept;
      head_ctl.last     = req_data.last;
      head_ctl.overflow = ovf_ff | full;
      head_ctl.cmp_len  = '0;
      head_ctl.best_len = '0;
   end

   assign chain_ctl[0] = head_ctl;
   assign chain_key[0] = key_in;
   assign chain_idx[0] = count_ff;

   // chain of cells, one per stored element
   generate
      for (genvar i = 0; i < MAX_N; i++) begin : g_cell
         lis_cell #(
            .POSITION    (i),
            .VALUE_WIDTH (VALUE_WIDTH),
            .IDX_W       (IDX_W)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .advance (advance),
            .in_ctl  (chain_ctl[i]),
            .in_key  (chain_key[i]),
            .in_idx  (chain_idx[i]),
            .out_ctl (chain_ctl[i+1]),
            .out_key (chain_key[i+1]),
            .out_idx (chain_idx[i+1])
         );
      end
   endgenerate

   // result register at the end of the chain
   assign rsp_load = advance && chain_ctl[MAX_N].valid && chain_ctl[MAX_N].last;

   always_comb begin
      rsp_valid_in         = rsp_valid_ff;
      rsp_data_in.length   = chain_ctl[MAX_N].best_len;
      rsp_data_in.overflow = chain_ctl[MAX_N].overflow;
      if (advance) begin
         rsp_valid_in = rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: verif/lis_length_checker.sv
// lis_length_checker: watches both channels of the subsequence length unit, predicts each
// result word from the accepted input words and compares field by field.
// Depends on lis_pkg for the word types and length limit.

module lis_length_checker #(
   parameter int unsigned MAX_N       = 256,
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  lis_pkg::lis_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  lis_pkg::lis_rsp_type rsp_data,
   output int                   fail_count,
   output int                   answers_due
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the unit's sequence state
   logic signed [VALUE_WIDTH-1:0]  seen_values  [MAX_N];
   logic [lis_pkg::LEN_W-1:0]      seen_lengths [MAX_N];
   int                             element_count = 0;
   int                             best_length   = 0;
   bit                             overflow_seen = 1'b0;

   lis_pkg::lis_rsp_type pending_answers [$];
   int mismatches = 0;
   int due_now    = 0;

   assign fail_count  = mismatches;
   assign answers_due = due_now;

   // Fold one element into the running answer; queue the answer on the last word
   task automatic absorb_element(input lis_pkg::lis_req_type w);
      logic signed [VALUE_WIDTH-1:0] key;
      int                            longest;
      int                            k;
      lis_pkg::lis_rsp_type          answer;
      key = w.value[VALUE_WIDTH-1:0];
      if (element_count < MAX_N) begin
         longest = 0;
         for (k = 0; k < element_count; k++) begin
            // strictly smaller only: equal values never extend a run
            if (seen_values[k] < key && seen_lengths[k] > longest)
               longest = seen_lengths[k];
         end
         longest = longest + 1;
         if (longest > lis_pkg::LEN_MAX)
            longest = lis_pkg::LEN_MAX;
         seen_values[element_count]  = key;
         seen_lengths[element_count] = longest[lis_pkg::LEN_W-1:0];
         element_count++;
         if (longest > best_length)
            best_length = longest;
      end else begin
         // table full: element dropped, only the flag remembers it
         overflow_seen = 1'b1;
      end
      if (w.last) begin
         answer.length   = best_length[lis_pkg::LEN_W-1:0];
         answer.overflow = overflow_seen;
         pending_answers.push_back(answer);
         element_count = 0;
         best_length   = 0;
         overflow_seen = 1'b0;
      end
   endtask

   // Compare result words in order, then take in the new input word
   always @(posedge clock) begin
      lis_pkg::lis_rsp_type want;
      if (reset) begin
         element_count = 0;
         best_length   = 0;
         overflow_seen = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               $error("unexpected result word: length %0d overflow %0b",
                      rsp_data.length, rsp_data.overflow);
               mismatches++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_data.length !== want.length) begin
                  $error("field length: expected %0d, actual %0d",
                         want.length, rsp_data.length);
                  mismatches++;
               end
               if (rsp_data.overflow !== want.overflow) begin
                  $error("field overflow: expected %0b, actual %0b",
                         want.overflow, rsp_data.overflow);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall)
            absorb_element(req_data);
      end
      due_now <= pending_answers.size();
   end

endmodule

// File: verif/longest_increasing_subsequence_length_unit_test.sv
// longest_increasing_subsequence_length_unit_test: clock, reset and stimulus for the
// subsequence length unit, with random idling on both channels and the final verdict.
// Depends on lis_pkg, the unit itself and lis_length_checker.

module longest_increasing_subsequence_length_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_N       = 256;
   localparam int unsigned VALUE_WIDTH = 32;

   typedef enum int {
      SPREAD_RANDOM,
      SPREAD_NARROW,
      SPREAD_RISING,
      SPREAD_FALLING,
      SPREAD_EXTREME
   } spread_type;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   lis_pkg::lis_req_type req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   lis_pkg::lis_rsp_type rsp_data;
   int                   fail_count;
   int                   answers_due;

   bit quiet      = 1'b0;
   int stall_left = 0;
   int items_fed  = 0;
   int seqs_fed   = 0;

   always #2 clock = ~clock;

   longest_increasing_subsequence_length_unit #(
      .MAX_N      (MAX_N),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   lis_length_checker #(
      .MAX_N      (MAX_N),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .answers_due(answers_due)
   );

   // Receiver back-pressure: stalled bursts of random length, none once quiet
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Offer one word, maybe after an idle burst, and hold it until taken
   task automatic feed_word(input logic signed [lis_pkg::IN_VALUE_W-1:0] v, input logic l);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data.value <= v;
      req_data.last  <= l;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic signed [31:0] pick_element(spread_type kind, int idx);
      logic signed [31:0] v;
      case (kind)
         SPREAD_NARROW:  v = $urandom_range(0, 8) - 4;
         SPREAD_RISING:  v = -1_000_000_000 + idx * 2_000_000 + $urandom_range(0, 1_999_999);
         SPREAD_FALLING: v = 1_000_000_000 - idx * 2_000_000 - $urandom_range(0, 1_999_999);
         SPREAD_EXTREME: begin
            case ($urandom_range(0, 4))
               0:       v = 32'sh8000_0000;
               1:       v = 32'sh7fff_ffff;
               2:       v = 0;
               3:       v = -1;
               default: v = 1;
            endcase
         end
         default:        v = $urandom();
      endcase
      return v;
   endfunction

   task automatic feed_sequence(input int n, input spread_type kind);
      int i;
      for (i = 0; i < n; i++)
         feed_word(pick_element(kind, i), i == n - 1);
      // words past the table are dropped by the unit
      items_fed += (n > MAX_N) ? MAX_N : n;
      seqs_fed++;
   endtask

   // Hold the sender off until every predicted result word has left
   task automatic drain_answers();
      req_valid <= 1'b0;
      @(posedge clock);
      while (answers_due != 0) @(posedge clock);
   endtask

   initial begin
      int         long_lengths [3];
      spread_type long_kinds   [3];
      int         long_idx;
      int         n;
      long_lengths = '{MAX_N, MAX_N + 1, MAX_N + 14};
      long_kinds   = '{SPREAD_RISING, SPREAD_RANDOM, SPREAD_RISING};
      long_idx     = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: single extremes, sign crossing, equal values, a classic mix
      feed_word(32'sh8000_0000, 1'b1);
      feed_word(32'sh7fff_ffff, 1'b1);
      feed_word(32'sh8000_0000, 1'b0);
      feed_word(32'sh7fff_ffff, 1'b1);
      feed_word(32'sh7fff_ffff, 1'b0);
      feed_word(32'sh8000_0000, 1'b1);
      feed_word(5, 1'b0);
      feed_word(5, 1'b0);
      feed_word(5, 1'b1);
      feed_word(-1, 1'b0);
      feed_word(0, 1'b0);
      feed_word(1, 1'b1);
      feed_word(3, 1'b0);
      feed_word(1, 1'b0);
      feed_word(2, 1'b0);
      feed_word(0, 1'b0);
      feed_word(4, 1'b1);
      feed_word(32'sh8000_0000, 1'b0);
      feed_word(-1, 1'b0);
      feed_word(32'sh7fff_ffff, 1'b0);
      feed_word(0, 1'b1);
      drain_answers();

      // Random sequences, mostly short, with a full table and two overflows mixed in
      while (items_fed < 850 || seqs_fed < 50 || long_idx < 3) begin
         if (long_idx < 3 && $urandom_range(0, 7) == 0) begin
            feed_sequence(long_lengths[long_idx], long_kinds[long_idx]);
            if (long_idx == 0)
               drain_answers();
            long_idx++;
         end else begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            feed_sequence(n, spread_type'($urandom_range(0, 4)));
         end
      end

      // Closing stretch at full rate on both sides
      quiet = 1'b1;
      while (items_fed < 950)
         feed_sequence($urandom_range(1, 12), spread_type'($urandom_range(0, 4)));

      drain_answers();
      repeat (MAX_N + 32) @(posedge clock);
      if (fail_count == 0 && answers_due == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
